// ===== sv/extended_gcd_unit_defines.svh =====
// assertion macros for the extended gcd unit
`ifndef EXTENDED_GCD_UNIT_DEFINES_SVH
`define EXTENDED_GCD_UNIT_DEFINES_SVH

// same-cycle implication, checked on clk outside reset
`define EGCD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk outside reset
`define EGCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/egcd_pkg.sv =====
// types shared by the extended gcd unit and its datapath modules
package egcd_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE,
    ST_FINISH
  } egcd_state_t;

  typedef struct packed {
    logic load;
    logic step;
  } egcd_ctl_t;

  typedef struct packed {
    logic qbit_valid;
    logic qbit;
    logic last;
  } egcd_div_stat_t;

endpackage

// ===== sv/egcd_div.sv =====
// bit-serial restoring divider on operand magnitudes, one quotient bit per cycle while ctl.step is high
module egcd_div
  import egcd_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  egcd_ctl_t            ctl,
  input  logic [WORD_BITS-1:0] num,
  input  logic [WORD_BITS-1:0] den,
  output egcd_div_stat_t       stat,
  output logic [WORD_BITS-1:0] rem_mag
);

  localparam int CNT_W = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0] rem_r, rem_nxt;
  logic [WORD_BITS-1:0] dvd_r, dvd_nxt;
  logic [WORD_BITS-1:0] dm_r, dm_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [WORD_BITS:0]   shifted;
  logic [WORD_BITS:0]   diff;
  logic                 ge;

  assign shifted = {rem_r, dvd_r[WORD_BITS-1]};
  assign ge      = shifted >= {1'b0, dm_r};
  assign diff    = shifted - {1'b0, dm_r};

  always_comb begin
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    dm_nxt  = dm_r;
    cnt_nxt = cnt_r;
    if (ctl.load) begin
      rem_nxt = '0;
      dvd_nxt = num[WORD_BITS-1] ? ('0 - num) : num;
      dm_nxt  = den[WORD_BITS-1] ? ('0 - den) : den;
      cnt_nxt = CNT_W'(WORD_BITS);
    end else if (ctl.step && (cnt_r != '0)) begin
      rem_nxt = ge ? diff[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
      dvd_nxt = {dvd_r[WORD_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dm_r  <= dm_nxt;
  end

  assign stat.qbit_valid = ctl.step && (cnt_r != '0);
  assign stat.qbit       = ge;
  assign stat.last       = ctl.step && (cnt_r == CNT_W'(1));
  assign rem_mag         = rem_r;

endmodule

// ===== sv/egcd_coef.sv =====
// msb-first shift-add products of the quotient with both running coefficients
module egcd_coef
  import egcd_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  egcd_ctl_t            ctl,
  input  egcd_div_stat_t       stat,
  input  logic [WORD_BITS-1:0] x1,
  input  logic [WORD_BITS-1:0] y1,
  output logic [WORD_BITS-1:0] px,
  output logic [WORD_BITS-1:0] py
);

  logic [WORD_BITS-1:0] px_r, px_nxt;
  logic [WORD_BITS-1:0] py_r, py_nxt;

  always_comb begin
    px_nxt = px_r;
    py_nxt = py_r;
    if (ctl.load) begin
      px_nxt = '0;
      py_nxt = '0;
    end else if (stat.qbit_valid) begin
      px_nxt = {px_r[WORD_BITS-2:0], 1'b0} + (stat.qbit ? x1 : '0);
      py_nxt = {py_r[WORD_BITS-2:0], 1'b0} + (stat.qbit ? y1 : '0);
    end
  end

  always_ff @(posedge clk) begin
    px_r <= px_nxt;
    py_r <= py_nxt;
  end

  assign px = px_r;
  assign py = py_r;

endmodule

// ===== sv/extended_gcd_unit.sv =====
// extended gcd unit: sequencer, remainder and coefficient registers, output register
//
// One item runs the extended Euclidean algorithm with truncating division and
// gives the last nonzero remainder with its two Bezout coefficients, all
// wrapping modulo 2^WORD_BITS, plus a flag if a step divided the minimum value
// by minus one. Each Euclid step passes through the check, divide and update
// states; in the divide state the bit-serial divider yields one quotient bit
// per cycle while the shift-add coefficient lanes consume it. in_stall is high
// from acceptance until the result is placed in the output register; a result
// waiting there does not block the next item.
module extended_gcd_unit
  import egcd_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [WORD_BITS-1:0] in_operand_a,
  input  logic signed [WORD_BITS-1:0] in_operand_b,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [WORD_BITS-1:0] out_gcd_value,
  output logic signed [WORD_BITS-1:0] out_coeff_a,
  output logic signed [WORD_BITS-1:0] out_coeff_b,
  output logic                        out_overflow
);

`include "extended_gcd_unit_defines.svh"

  localparam logic [WORD_BITS-1:0] MIN_VAL = {1'b1, {(WORD_BITS-1){1'b0}}};

  egcd_state_t          state_r, state_nxt;
  egcd_ctl_t            ctl;
  egcd_div_stat_t       stat;
  logic                 out_load;

  logic [WORD_BITS-1:0] r0_r, r0_nxt, r1_r, r1_nxt;
  logic [WORD_BITS-1:0] x0_r, x0_nxt, x1_r, x1_nxt;
  logic [WORD_BITS-1:0] y0_r, y0_nxt, y1_r, y1_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [WORD_BITS-1:0] out_gcd_r, out_ca_r, out_cb_r;
  logic                 out_ovf_r;

  logic [WORD_BITS-1:0] rem_mag, px, py;
  logic                 q_neg;

  egcd_div #(.WORD_BITS(WORD_BITS)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .num     (r0_r),
    .den     (r1_r),
    .stat    (stat),
    .rem_mag (rem_mag)
  );

  egcd_coef #(.WORD_BITS(WORD_BITS)) u_coef (
    .clk  (clk),
    .ctl  (ctl),
    .stat (stat),
    .x1   (x1_r),
    .y1   (y1_r),
    .px   (px),
    .py   (py)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = (r1_r == '0) ? ST_FINISH : ST_DIV;
      ST_DIV:    if (stat.last) state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_CHECK;
      ST_FINISH: if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall = (state_r != ST_IDLE);
    ctl.load = (state_r == ST_CHECK) && (r1_r != '0);
    ctl.step = (state_r == ST_DIV);
    out_load = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);
  end

  assign q_neg = r0_r[WORD_BITS-1] ^ r1_r[WORD_BITS-1];

  always_comb begin
    r0_nxt  = r0_r;
    r1_nxt  = r1_r;
    x0_nxt  = x0_r;
    x1_nxt  = x1_r;
    y0_nxt  = y0_r;
    y1_nxt  = y1_r;
    ovf_nxt = ovf_r;
    if ((state_r == ST_IDLE) && in_valid) begin
      r0_nxt  = in_operand_a;
      r1_nxt  = in_operand_b;
      x0_nxt  = WORD_BITS'(1);
      x1_nxt  = '0;
      y0_nxt  = '0;
      y1_nxt  = WORD_BITS'(1);
      ovf_nxt = 1'b0;
    end else if (ctl.load) begin
      if ((r0_r == MIN_VAL) && (r1_r == '1)) begin
        ovf_nxt = 1'b1;
      end
    end else if (state_r == ST_UPDATE) begin
      r0_nxt = r1_r;
      r1_nxt = r0_r[WORD_BITS-1] ? ('0 - rem_mag) : rem_mag;
      x0_nxt = x1_r;
      x1_nxt = q_neg ? (x0_r + px) : (x0_r - px);
      y0_nxt = y1_r;
      y1_nxt = q_neg ? (y0_r + py) : (y0_r - py);
    end
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r0_r  <= r0_nxt;
    r1_r  <= r1_nxt;
    x0_r  <= x0_nxt;
    x1_r  <= x1_nxt;
    y0_r  <= y0_nxt;
    y1_r  <= y1_nxt;
    ovf_r <= ovf_nxt;
    if (out_load) begin
      out_gcd_r <= r0_r;
      out_ca_r  <= x0_r;
      out_cb_r  <= y0_r;
      out_ovf_r <= ovf_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_gcd_value = out_gcd_r;
  assign out_coeff_a   = out_ca_r;
  assign out_coeff_b   = out_cb_r;
  assign out_overflow  = out_ovf_r;

  `EGCD_ASSERT_NEXT(a_accept_to_check, in_valid && !in_stall, state_r == ST_CHECK, "accepted item did not start a step check")
  `EGCD_ASSERT_SAME(a_update_after_div, state_r == ST_UPDATE, $past(state_r) == ST_DIV, "update without a finished division")
  `EGCD_ASSERT_SAME(a_finish_on_zero, state_r == ST_FINISH, r1_r == '0, "finished with a nonzero second remainder")
  `EGCD_ASSERT_NEXT(a_hold_pending, state_r == ST_FINISH && out_valid_r && out_stall, state_r == ST_FINISH && out_valid_r, "pending result overwritten")

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for the extended gcd unit: directed corners, random operands, idling
`timescale 1ns / 1ps

module tb_top;

  localparam int WORD_BITS = 32;
  localparam int STUCK_LIMIT = 16000;
  localparam int DRAIN_CYCLES = 50;
  localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] MINUS_ONE = '1;

  typedef struct packed {
    logic [WORD_BITS-1:0] gcd_value;
    logic [WORD_BITS-1:0] coeff_a;
    logic [WORD_BITS-1:0] coeff_b;
    logic                 overflow;
  } bezout_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic signed [WORD_BITS-1:0] in_operand_a = '0;
  logic signed [WORD_BITS-1:0] in_operand_b = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic signed [WORD_BITS-1:0] out_gcd_value;
  logic signed [WORD_BITS-1:0] out_coeff_a;
  logic signed [WORD_BITS-1:0] out_coeff_b;
  logic out_overflow;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent = 0;
  int results_checked = 0;
  int overflow_seen = 0;
  int mismatches = 0;
  bezout_t bezout_q[$];

  wire in_fire = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;

  extended_gcd_unit #(.WORD_BITS(WORD_BITS)) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_gcd_value(out_gcd_value),
    .out_coeff_a  (out_coeff_a),
    .out_coeff_b  (out_coeff_b),
    .out_overflow (out_overflow)
  );

  always #5 clk = ~clk;

  // euclid with truncating division, all arithmetic wrapping at the word width
  function automatic bezout_t predict_bezout(input logic [WORD_BITS-1:0] a,
                                             input logic [WORD_BITS-1:0] b);
    logic [WORD_BITS-1:0] r0, r1, x0, x1, y0, y1, q, rem, t, nm, dm, qm, rm;
    logic ovf;
    bezout_t res;
    r0 = a;
    r1 = b;
    x0 = 1;
    x1 = 0;
    y0 = 0;
    y1 = 1;
    ovf = 1'b0;
    while (r1 != '0) begin
      nm = r0[WORD_BITS-1] ? -r0 : r0;
      dm = r1[WORD_BITS-1] ? -r1 : r1;
      qm = nm / dm;
      rm = nm % dm;
      q = (r0[WORD_BITS-1] != r1[WORD_BITS-1]) ? -qm : qm;
      rem = r0[WORD_BITS-1] ? -rm : rm;
      if (r0 == WORD_MIN && r1 == MINUS_ONE) ovf = 1'b1;
      t = x0 - q * x1;
      x0 = x1;
      x1 = t;
      t = y0 - q * y1;
      y0 = y1;
      y1 = t;
      r0 = r1;
      r1 = rem;
    end
    res.gcd_value = r0;
    res.coeff_a = x0;
    res.coeff_b = y0;
    res.overflow = ovf;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [WORD_BITS-1:0] exp_v,
                                      input logic [WORD_BITS-1:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
    end
  endfunction

  function automatic logic [WORD_BITS-1:0] rand_sign(input logic [WORD_BITS-1:0] v);
    return ($urandom_range(1) == 1) ? -v : v;
  endfunction

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    bezout_t want;
    if (rst_n) begin
      if (in_fire) bezout_q.push_back(predict_bezout(in_operand_a, in_operand_b));
      if (out_fire) begin
        if (bezout_q.size() == 0) begin
          mismatches++;
          $display("%0t unexpected result: expected none actual %h %h %h %b", $time,
                   out_gcd_value, out_coeff_a, out_coeff_b, out_overflow);
        end else begin
          want = bezout_q.pop_front();
          results_checked++;
          if (out_overflow === 1'b1) overflow_seen++;
          check_field("gcd_value", want.gcd_value, out_gcd_value);
          check_field("coeff_a", want.coeff_a, out_coeff_a);
          check_field("coeff_b", want.coeff_b, out_coeff_b);
          check_field("overflow", WORD_BITS'(want.overflow), WORD_BITS'(out_overflow));
        end
      end
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if (in_fire || out_fire) stuck = 0;
      else stuck++;
    end
    $display("timeout after %0d cycles with no item moving", STUCK_LIMIT);
    $display("status: fail");
    $finish;
  end

  task automatic send_item(input logic [WORD_BITS-1:0] a, input logic [WORD_BITS-1:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic test_zero_divisor();
    send_item(32'd12345, '0);
    send_item('0, '0);
    send_item(WORD_MIN, '0);
    send_item(MINUS_ONE, '0);
    send_item('0, 32'd7);
    send_item('0, WORD_MIN);
  endtask

  task automatic test_minimum_by_minus_one();
    send_item(WORD_MIN, MINUS_ONE);
    send_item(MINUS_ONE, WORD_MIN);
    send_item(WORD_MIN, 32'd1);
  endtask

  task automatic test_word_extremes();
    send_item(WORD_MAX, WORD_MIN);
    send_item(WORD_MIN, WORD_MAX);
    send_item(WORD_MIN, WORD_MIN);
    send_item(WORD_MAX, WORD_MAX);
    send_item(MINUS_ONE, MINUS_ONE);
    send_item(WORD_MAX, 32'd2);
    send_item(32'h5555_5555, 32'hAAAA_AAAA);
    send_item(32'hAAAA_AAAA, 32'h5555_5555);
  endtask

  task automatic test_long_chains();
    send_item(32'd1836311903, 32'd1134903170);
    send_item(-32'd1836311903, 32'd1134903170);
    send_item(32'd1134903170, -32'd1836311903);
  endtask

  task automatic test_signs();
    send_item(32'd240, 32'd46);
    send_item(-32'd240, 32'd46);
    send_item(32'd240, -32'd46);
    send_item(-32'd240, -32'd46);
  endtask

  task automatic test_random_mix(input int count);
    logic [WORD_BITS-1:0] a, b, g, f0, f1, t;
    int steps;
    repeat (count) begin
      a = $urandom();
      b = $urandom();
      case ($urandom_range(9))
        4: begin
          a = rand_sign($urandom_range(2000));
          b = rand_sign($urandom_range(2000));
        end
        5: begin
          g = $urandom_range(1, 65535);
          a = rand_sign(g * $urandom_range(32767));
          b = rand_sign(g * $urandom_range(32767));
        end
        6: begin
          case ($urandom_range(4))
            0: b = '0;
            1: a = '0;
            2: a = WORD_MIN;
            3: b = WORD_MIN;
            default: begin
              a = WORD_MIN;
              b = MINUS_ONE;
            end
          endcase
        end
        7: begin
          steps = $urandom_range(2, 45);
          f0 = 0;
          f1 = 1;
          repeat (steps) begin
            t = f0 + f1;
            f0 = f1;
            f1 = t;
          end
          a = rand_sign(f1);
          b = rand_sign(f0);
        end
        8: b = rand_sign($urandom_range(1, 300));
        9: begin
          b = rand_sign($urandom_range(1, 65535));
          a = b * rand_sign($urandom_range(32767));
        end
        default: ;
      endcase
      send_item(a, b);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 7;
    recv_idle_pct = 62;
    test_zero_divisor();
    test_minimum_by_minus_one();
    test_word_extremes();
    test_long_chains();
    test_signs();
    test_random_mix(130);

    send_idle_pct = 62;
    recv_idle_pct = 7;
    test_random_mix(130);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(140);

    in_valid <= 1'b0;
    while (bezout_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d operand pairs (directed corners, then random under three idling mixes)",
             items_sent);
    $display("checked %0d results, %0d with overflow set, %0d mismatches",
             results_checked, overflow_seen, mismatches);
    if (mismatches == 0 && bezout_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
